// ===== rtl/segment_triangle_intersect_defines.svh =====
// ----------------------------------------------------------------------------
// segment_triangle_intersect assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define STI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define STI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// Widths, register codes and shared types of the segment/triangle test.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int          FRAC_BITS_DEF = 8;
  localparam logic [63:0] FAR_Z_UNITS   = 64'd9999999;

  localparam int COORD_W = 32;   // input coordinate
  localparam int ZCFG_W  = 40;   // segment z ends
  localparam int REL_W   = 33;   // x,y relative to the segment
  localparam int RELZ_W  = 41;   // z relative to the segment start
  localparam int PROD_W  = 66;   // 2d cross partial product
  localparam int EDGE_W  = 67;   // 2d cross product / normal z
  localparam int WMUL_W  = 108;  // z times 2d cross
  localparam int NUM_W   = 110;  // sum of three wide products
  localparam int QUO_W   = 41;   // |t*dz| fits here on a hit

  localparam logic CFG_Z_LOW  = 1'b0;
  localparam logic CFG_Z_HIGH = 1'b1;

  typedef struct packed {
    logic hit;
    logic neg;
  } div_side_t;

endpackage

// ===== rtl/sti_wmul.sv =====
// ----------------------------------------------------------------------------
// sti_wmul
// Two-stage signed 41x67 multiply built from four narrow partial products.
// ----------------------------------------------------------------------------
module sti_wmul (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [sti_pkg::RELZ_W-1:0]     a_i,
  input  logic signed [sti_pkg::EDGE_W-1:0]     b_i,
  output logic signed [sti_pkg::WMUL_W-1:0]     p_o
);

  localparam int LO_W = 32;
  localparam int AH_W = sti_pkg::RELZ_W - LO_W;
  localparam int BH_W = sti_pkg::EDGE_W - LO_W;

  logic        [2*LO_W-1:0]       p_ll_d, p_ll_q;
  logic signed [LO_W+BH_W:0]      p_lh_d, p_lh_q;
  logic signed [LO_W+AH_W:0]      p_hl_d, p_hl_q;
  logic signed [AH_W+BH_W-1:0]    p_hh_d, p_hh_q;
  logic signed [sti_pkg::WMUL_W-1:0] p_d, p_q;

  assign p_ll_d = a_i[LO_W-1:0] * b_i[LO_W-1:0];
  assign p_lh_d = $signed({1'b0, a_i[LO_W-1:0]}) * $signed(b_i[sti_pkg::EDGE_W-1:LO_W]);
  assign p_hl_d = $signed(a_i[sti_pkg::RELZ_W-1:LO_W]) * $signed({1'b0, b_i[LO_W-1:0]});
  assign p_hh_d = $signed(a_i[sti_pkg::RELZ_W-1:LO_W]) * $signed(b_i[sti_pkg::EDGE_W-1:LO_W]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ll_q <= p_ll_d;
      p_lh_q <= p_lh_d;
      p_hl_q <= p_hl_d;
      p_hh_q <= p_hh_d;
    end
  end

  assign p_d = $signed({{(sti_pkg::WMUL_W-2*LO_W){1'b0}}, p_ll_q})
             + (sti_pkg::WMUL_W'(p_lh_q) <<< LO_W)
             + (sti_pkg::WMUL_W'(p_hl_q) <<< LO_W)
             + (sti_pkg::WMUL_W'(p_hh_q) <<< (2*LO_W));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/sti_div.sv =====
// ----------------------------------------------------------------------------
// sti_div
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module sti_div #(
  parameter int NUM_W = sti_pkg::NUM_W,
  parameter int DEN_W = sti_pkg::EDGE_W,
  parameter int Q_W   = sti_pkg::QUO_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [DEN_W-1:0]           den_i,
  input  sti_pkg::div_side_t         side_i,
  output logic                       vld_o,
  output logic [Q_W-1:0]             quo_o,
  output sti_pkg::div_side_t         side_o
);

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int SH = Q_W - 1 - i;
    logic               vld_in;
    logic [NUM_W-1:0]   rem_in;
    logic [DEN_W-1:0]   den_in;
    logic [Q_W-1:0]     quo_in;
    sti_pkg::div_side_t side_in;
    logic               vld_q;
    logic [NUM_W-1:0]   rem_q;
    logic [DEN_W-1:0]   den_q;
    logic [Q_W-1:0]     quo_q;
    sti_pkg::div_side_t side_q;
    logic [NUM_W:0]     trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = g_stage[i-1].vld_q;
      assign rem_in  = g_stage[i-1].rem_q;
      assign den_in  = g_stage[i-1].den_q;
      assign quo_in  = g_stage[i-1].quo_q;
      assign side_in = g_stage[i-1].side_q;
    end

    // the remainder stays below den << (SH + 1) on a real hit
    assign trial = {1'b0, rem_in} - ((NUM_W+1)'(den_in) << SH);
    assign ge    = !trial[NUM_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? trial[NUM_W-1:0] : rem_in;
        den_q  <= den_in;
        quo_q  <= {quo_in[Q_W-2:0], ge};
        side_q <= side_in;
      end
    end
  end

  assign vld_o  = g_stage[Q_W-1].vld_q;
  assign quo_o  = g_stage[Q_W-1].quo_q;
  assign side_o = g_stage[Q_W-1].side_q;

endmodule

// ===== rtl/segment_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// Vertical segment against triangle test with exact signed volumes.
// ----------------------------------------------------------------------------
// One triangle and one segment x,y per item; the segment z ends come from
// the two config registers. The block takes one item per clock and returns
// one result per item, through stages for the edge cross products, the wide
// products and the sign tests, then the divider that finds the crossing z
// (one quotient bit per stage) and one output register. A stalled output
// freezes the whole pipeline and stops the block from taking items.
// Config writes are taken at any time but must only be done while the
// pipeline is empty.
`include "segment_triangle_intersect_defines.svh"

module segment_triangle_intersect #(
  parameter int FRAC_BITS = sti_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_addr_i,
  input  logic [sti_pkg::ZCFG_W-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z, line_x, line_y (32 bits each)
  input  logic [11*sti_pkg::COORD_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit [0], hit_z [40:1], zero [47:41]
  output logic [47:0]                  m_axis_tdata
);

  localparam int CW = sti_pkg::COORD_W;
  localparam int RW = sti_pkg::REL_W;
  localparam int ZW = sti_pkg::RELZ_W;
  localparam int PW = sti_pkg::PROD_W;
  localparam int EW = sti_pkg::EDGE_W;
  localparam int MW = sti_pkg::WMUL_W;
  localparam int NW = sti_pkg::NUM_W;
  localparam int QW = sti_pkg::QUO_W;
  localparam int LW = sti_pkg::ZCFG_W;

  localparam logic [LW-1:0] Z_FAR = LW'(sti_pkg::FAR_Z_UNITS << FRAC_BITS);

  // configuration
  logic [LW-1:0] zl_q, zh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zl_q <= LW'(0) - Z_FAR;
      zh_q <= Z_FAR;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sti_pkg::CFG_Z_LOW:  zl_q <= cfg_wdata_i;
        sti_pkg::CFG_Z_HIGH: zh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic       en;
  logic [8:1] vld_q;
  logic       out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:1], s_axis_tvalid};
    end
  end

  // stage 1: coordinates relative to the segment start
  logic signed [CW-1:0] f [11];
  for (genvar k = 0; k < 11; k++) begin : g_field
    assign f[k] = $signed(s_axis_tdata[k*CW +: CW]);
  end

  logic signed [RW-1:0] ax1_q, ay1_q, bx1_q, by1_q, cx1_q, cy1_q;
  logic signed [ZW-1:0] az1_q, bz1_q, cz1_q, dz1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= RW'(f[0]) - RW'(f[9]);
      ay1_q <= RW'(f[1]) - RW'(f[10]);
      az1_q <= ZW'(f[2]) - ZW'($signed(zl_q));
      bx1_q <= RW'(f[3]) - RW'(f[9]);
      by1_q <= RW'(f[4]) - RW'(f[10]);
      bz1_q <= ZW'(f[5]) - ZW'($signed(zl_q));
      cx1_q <= RW'(f[6]) - RW'(f[9]);
      cy1_q <= RW'(f[7]) - RW'(f[10]);
      cz1_q <= ZW'(f[8]) - ZW'($signed(zl_q));
      dz1_q <= ZW'($signed(zh_q)) - ZW'($signed(zl_q));
    end
  end

  // stage 2: 2d cross partial products
  logic signed [PW-1:0] pab1_q, pab2_q, pbc1_q, pbc2_q, pca1_q, pca2_q;
  logic signed [ZW-1:0] az2_q, bz2_q, cz2_q, dz2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pab1_q <= ax1_q * by1_q;
      pab2_q <= ay1_q * bx1_q;
      pbc1_q <= bx1_q * cy1_q;
      pbc2_q <= by1_q * cx1_q;
      pca1_q <= cx1_q * ay1_q;
      pca2_q <= cy1_q * ax1_q;
      az2_q  <= az1_q;
      bz2_q  <= bz1_q;
      cz2_q  <= cz1_q;
      dz2_q  <= dz1_q;
    end
  end

  // stage 3: edge functions around the segment
  logic signed [EW-1:0] eab3_q, ebc3_q, eca3_q;
  logic signed [ZW-1:0] az3_q, bz3_q, cz3_q, dz3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      eab3_q <= EW'(pab1_q) - EW'(pab2_q);
      ebc3_q <= EW'(pbc1_q) - EW'(pbc2_q);
      eca3_q <= EW'(pca1_q) - EW'(pca2_q);
      az3_q  <= az2_q;
      bz3_q  <= bz2_q;
      cz3_q  <= cz2_q;
      dz3_q  <= dz2_q;
    end
  end

  // stage 4: normal z and edge sign agreement
  logic                 sab_n, sbc_n, sca_n, sab_z, sbc_z, sca_z;
  logic signed [EW-1:0] eab4_q, ebc4_q, eca4_q, nz4_q;
  logic signed [ZW-1:0] az4_q, bz4_q, cz4_q, dz4_q;
  logic                 eok4_q;

  assign sab_n = eab3_q[EW-1];
  assign sbc_n = ebc3_q[EW-1];
  assign sca_n = eca3_q[EW-1];
  assign sab_z = (eab3_q == '0);
  assign sbc_z = (ebc3_q == '0);
  assign sca_z = (eca3_q == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      eab4_q <= eab3_q;
      ebc4_q <= ebc3_q;
      eca4_q <= eca3_q;
      // the sum is exact in this width
      nz4_q  <= eab3_q + ebc3_q + eca3_q;
      eok4_q <= (sab_n == sbc_n) && (sbc_n == sca_n) &&
                (sab_z == sbc_z) && (sbc_z == sca_z);
      az4_q  <= az3_q;
      bz4_q  <= bz3_q;
      cz4_q  <= cz3_q;
      dz4_q  <= dz3_q;
    end
  end

  // stages 5-6: wide products
  logic signed [MW-1:0] m_a, m_b, m_c, m_d;

  sti_wmul u_mul_a (.clk_i, .en_i(en), .a_i(az4_q), .b_i(ebc4_q), .p_o(m_a));
  sti_wmul u_mul_b (.clk_i, .en_i(en), .a_i(bz4_q), .b_i(eca4_q), .p_o(m_b));
  sti_wmul u_mul_c (.clk_i, .en_i(en), .a_i(cz4_q), .b_i(eab4_q), .p_o(m_c));
  sti_wmul u_mul_d (.clk_i, .en_i(en), .a_i(dz4_q), .b_i(nz4_q),  .p_o(m_d));

  logic signed [EW-1:0] nz5_q, nz6_q;
  logic                 eok5_q, eok6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nz5_q  <= nz4_q;
      nz6_q  <= nz5_q;
      eok5_q <= eok4_q;
      eok6_q <= eok5_q;
    end
  end

  // stage 7: volume at the segment start
  logic signed [NW-1:0] num7_q;
  logic signed [MW-1:0] pd7_q;
  logic signed [EW-1:0] nz7_q;
  logic                 eok7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num7_q <= NW'(m_a) + NW'(m_b) + NW'(m_c);
      pd7_q  <= m_d;
      nz7_q  <= nz6_q;
      eok7_q <= eok6_q;
    end
  end

  // stage 8: end signs, magnitudes for the divider
  logic signed [NW-1:0] vol_hi;
  logic                 ends_differ;
  logic [NW-1:0]        num8_q;
  logic [EW-1:0]        den8_q;
  sti_pkg::div_side_t   side8_q;

  assign vol_hi      = num7_q - NW'(pd7_q);
  assign ends_differ = (num7_q[NW-1] != vol_hi[NW-1]) ||
                       ((num7_q == '0) != (vol_hi == '0));

  always_ff @(posedge clk_i) begin
    if (en) begin
      num8_q      <= num7_q[NW-1] ? NW'(-num7_q) : NW'(num7_q);
      den8_q      <= nz7_q[EW-1] ? EW'(-nz7_q) : EW'(nz7_q);
      side8_q.hit <= eok7_q && ends_differ;
      side8_q.neg <= num7_q[NW-1] ^ nz7_q[EW-1];
    end
  end

  // crossing depth
  logic               dv_vld;
  logic [QW-1:0]      dv_quo;
  sti_pkg::div_side_t dv_side;

  sti_div #(
    .NUM_W (NW),
    .DEN_W (EW),
    .Q_W   (QW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .en_i   (en),
    .vld_i  (vld_q[8]),
    .num_i  (num8_q),
    .den_i  (den8_q),
    .side_i (side8_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // output register
  logic [QW-1:0] q_signed;
  logic [LW-1:0] hz_d, hz_q;
  logic          hit_q;

  assign q_signed = dv_side.neg ? (QW'(0) - dv_quo) : dv_quo;
  assign hz_d     = dv_side.hit ? (zl_q + q_signed[LW-1:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= dv_side.hit;
      hz_q  <= hz_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, hz_q, hit_q};

  `STI_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[40:1] == '0, "miss item carries nonzero z")
  `STI_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[1], "accepted item not in first stage")
  `STI_ASSERT_IMP(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")

endmodule
